>>> src/sapl_pkg.sv
// Shared widths, register indexes and arithmetic constants for the servo
// angle-to-pulse block. No dependencies.
`timescale 1ns / 1ps

package sapl_pkg;

    localparam int CH_W       = 3;
    localparam int ANGLE_W    = 16;
    localparam int COUNT_W    = 20;
    localparam int CPU_W      = 8;
    localparam int GAIN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Pulse width in Q.8 microseconds: 20 bits holds 128000..640000.
    localparam int WIDTH_W    = 20;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCKS_PER_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;

    localparam logic [CPU_W-1:0]  CPU_RESET  = 8'd50;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd90;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 9'd256;

    // +/-90 degrees in Q8.8.
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;
    // 500 us in Q.8.
    localparam logic [WIDTH_W-1:0] BASE_WIDTH = 20'd128000;

    // mapped*100/9 = 11*mapped + mapped/9; mapped/9 by reciprocal, exact for
    // mapped up to 46080.
    localparam logic [WIDTH_W-1:0] WIDTH_MUL    = 20'd11;
    localparam logic [15:0]        RECIP9       = 16'd58255;
    localparam int                 RECIP9_SHIFT = 19;

endpackage

>>> src/sapl_if.sv
// Handshake interfaces for the command, result and configuration channels.
// Depends on sapl_pkg.
`timescale 1ns / 1ps

interface sapl_cmd_if import sapl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CH_W-1:0]           channel_index;
    logic signed [ANGLE_W-1:0] command_angle;

    modport source (output valid, channel_index, command_angle, input ready);
    modport sink   (input valid, channel_index, command_angle, output ready);
endinterface

interface sapl_res_if import sapl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CH_W-1:0]           channel_out;
    logic [COUNT_W-1:0]        high_counts;
    logic signed [ANGLE_W-1:0] feedback_angle;

    modport source (output valid, channel_out, high_counts, feedback_angle, input ready);
    modport sink   (input valid, channel_out, high_counts, feedback_angle, output ready);
endinterface

interface sapl_cfg_if import sapl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sapl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sapl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/servo_angle_to_pulse_with_lag.sv
// Servo angle-to-pulse mapper with per-channel simulated feedback lag.
// A command is registered, then runs through READ, CALC and MUL into the output
// register; a new command is taken only back in IDLE, and a held result stalls MUL.
// Out-of-range channels are dropped in the transfer cycle with no result.
// Reset (rst_n low, async): registers to 50 / 90, feedback reads as zero through
// per-entry valid bits; no clearing pass. Depends on sapl_pkg, sapl_if, sapl_ram.
`timescale 1ns / 1ps

module servo_angle_to_pulse_with_lag import sapl_pkg::*; #(
    parameter int CHANNELS = 6
) (
    input logic       clk,
    input logic       rst_n,
    sapl_cmd_if.sink  cmd,
    sapl_res_if.source res,
    sapl_cfg_if.sink  cfg
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

    // Sequencer: IDLE takes a command and issues the RAM read, READ does
    // clamp/map and the feedback error product, CALC finishes the width and
    // writes back feedback, MUL scales by clock rate into the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_MUL
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [CPU_W-1:0]  cpu_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Item being worked on.
    logic [CH_W-1:0]           ch_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [15:0]               mapped_reg;
    logic [31:0]               q9_prod_reg;
    logic signed [ANGLE_W-1:0] fb_reg;
    logic signed [26:0]        fb_prod_reg;
    logic [WIDTH_W-1:0]        width_reg;

    // Result holding register.
    logic                      out_valid_reg;
    logic [CH_W-1:0]           out_ch_reg;
    logic [COUNT_W-1:0]        out_counts_reg;
    logic signed [ANGLE_W-1:0] out_fb_reg;

    // Feedback entries that have been written since reset.
    logic [CHANNELS-1:0] fb_valid_reg;

    // RAM connections.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ANGLE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ANGLE_W-1:0] ram_rdata;

    logic cmd_xfer;
    logic cmd_in_range;
    logic out_free;

    // READ-stage logic.
    logic signed [ANGLE_W-1:0] angle_clamped;
    logic signed [ANGLE_W:0]   mapped_full;
    logic [15:0]               mapped;
    logic signed [ANGLE_W-1:0] fb_cur;
    logic signed [ANGLE_W:0]   fb_diff;
    logic [GAIN_W-1:0]         gain_sat;

    // CALC-stage logic.
    logic [WIDTH_W-1:0]        width_next;
    logic signed [26:0]        fb_step;
    logic signed [26:0]        fb_sum;
    logic signed [ANGLE_W-1:0] fb_next;

    // MUL-stage logic.
    logic [CPU_W+WIDTH_W-1:0]  counts_full;

    assign cmd.ready    = (state_reg == S_IDLE);
    assign cmd_xfer     = cmd.valid && cmd.ready;
    assign cmd_in_range = ({1'b0, cmd.channel_index} < CH_LIMIT);
    assign out_free     = !out_valid_reg || res.ready;

    assign cfg.ready = 1'b1;

    assign res.valid          = out_valid_reg;
    assign res.channel_out    = out_ch_reg;
    assign res.high_counts    = out_counts_reg;
    assign res.feedback_angle = out_fb_reg;

    // Read the feedback entry straight from the transfer so it lands in READ.
    assign ram_re    = cmd_xfer && cmd_in_range;
    assign ram_raddr = cmd.channel_index[AW-1:0];
    assign ram_we    = (state_reg == S_CALC);
    assign ram_waddr = ch_reg[AW-1:0];
    assign ram_wdata = fb_next;

    sapl_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (CHANNELS)
    ) u_fb_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        // Clamp to +/-90 degrees, then invert into 0..180.
        if (angle_reg > ANGLE_LIMIT)
        begin
            angle_clamped = ANGLE_LIMIT;
        end
        else if (angle_reg < -ANGLE_LIMIT)
        begin
            angle_clamped = -ANGLE_LIMIT;
        end
        else
        begin
            angle_clamped = angle_reg;
        end
        mapped_full = {ANGLE_LIMIT[ANGLE_W-1], ANGLE_LIMIT}
                    - {angle_clamped[ANGLE_W-1], angle_clamped};
        mapped = mapped_full[15:0];

        // Never-written entries read as zero.
        fb_cur   = fb_valid_reg[ch_reg[AW-1:0]] ? $signed(ram_rdata) : '0;
        fb_diff  = {angle_reg[ANGLE_W-1], angle_reg} - {fb_cur[ANGLE_W-1], fb_cur};
        gain_sat = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;

        width_next = BASE_WIDTH + WIDTH_MUL * WIDTH_W'(mapped_reg)
                   + WIDTH_W'(q9_prod_reg[31:RECIP9_SHIFT]);

        // Arithmetic shift gives the floor of gain*diff/256.
        fb_step = fb_prod_reg >>> 8;
        fb_sum  = 27'(fb_reg) + fb_step;
        fb_next = fb_sum[ANGLE_W-1:0];

        counts_full = (CPU_W + WIDTH_W)'(cpu_reg) * (CPU_W + WIDTH_W)'(width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg  <= CPU_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_CLOCKS_PER_US: cpu_reg  <= cfg.data[CPU_W-1:0];
                CFG_FEEDBACK_GAIN: gain_reg <= cfg.data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            ch_reg    <= cmd.channel_index;
            angle_reg <= cmd.command_angle;
        end
        if (state_reg == S_READ)
        begin
            mapped_reg  <= mapped;
            q9_prod_reg <= 32'(mapped) * 32'(RECIP9);
            fb_reg      <= fb_cur;
            fb_prod_reg <= $signed({1'b0, gain_sat}) * fb_diff;
        end
        // Keep the updated feedback here; the output register may still hold
        // the previous result.
        if (state_reg == S_CALC)
        begin
            width_reg <= width_next;
            fb_reg    <= fb_next;
        end
        if (state_reg == S_MUL && out_free)
        begin
            out_ch_reg     <= ch_reg;
            out_counts_reg <= counts_full[CPU_W+WIDTH_W-1:8];
            out_fb_reg     <= fb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fb_valid_reg  <= '0;
        end
        else
        begin
            // Load a new result, or drop the old one once it is taken.
            if (state_reg == S_MUL && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    // Drop out-of-range channels here.
                    if (cmd_xfer && cmd_in_range)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    fb_valid_reg[ch_reg[AW-1:0]] <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // Hold until the previous result has been taken.
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> verif/servo_pulse_tb_pkg.sv
// Pulse-width and feedback-lag scoreboard for the servo angle-to-pulse testbench.
// Depends on sapl_pkg for widths, register indexes and arithmetic constants.
`timescale 1ns / 1ps

package servo_pulse_tb_pkg;
    import sapl_pkg::*;

    typedef struct {
        logic [CH_W-1:0]           channel;
        logic [COUNT_W-1:0]        counts;
        logic signed [ANGLE_W-1:0] feedback;
    } pulse_result_t;

    class pulse_scoreboard;
        localparam int MAX_REPORTS = 10;

        int                        n_channels;
        logic [CPU_W-1:0]          clocks_per_us;
        logic [GAIN_W-1:0]         lag_gain;
        logic signed [ANGLE_W-1:0] feedback_mem [8];
        pulse_result_t             pulse_q [$];
        int                        commands;
        int                        dropped;
        int                        results;
        int                        mismatches;

        function new(int channels);
            n_channels    = channels;
            clocks_per_us = CPU_RESET;
            lag_gain      = GAIN_RESET;
            foreach (feedback_mem[i])
                feedback_mem[i] = '0;
            commands   = 0;
            dropped    = 0;
            results    = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CLOCKS_PER_US: clocks_per_us = data[CPU_W-1:0];
                CFG_FEEDBACK_GAIN: lag_gain      = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Compute the pulse count and the lagged feedback for one accepted command.
        function void note_command(logic [CH_W-1:0] ch, logic signed [ANGLE_W-1:0] angle);
            int            lim;
            int            clamped;
            int            mapped;
            int            width_q8;
            int            gain_eff;
            longint        counts_full;
            longint        err;
            longint        fb_next;
            pulse_result_t exp_r;
            commands++;
            if (ch >= n_channels)
            begin
                dropped++;
                return;
            end
            lim     = ANGLE_LIMIT;
            clamped = angle;
            if (clamped < -lim)
                clamped = -lim;
            if (clamped > lim)
                clamped = lim;
            mapped      = lim - clamped;
            width_q8    = int'(BASE_WIDTH) + (mapped * 100) / 9;
            counts_full = (longint'(clocks_per_us) * width_q8) >>> 8;

            gain_eff = (lag_gain > GAIN_MAX) ? int'(GAIN_MAX) : int'(lag_gain);
            err      = longint'(angle) - longint'(feedback_mem[ch]);
            fb_next  = longint'(feedback_mem[ch]) + ((gain_eff * err) >>> 8);
            if (fb_next > 32767)
                fb_next = 32767;
            if (fb_next < -32768)
                fb_next = -32768;
            feedback_mem[ch] = fb_next[ANGLE_W-1:0];

            exp_r.channel  = ch;
            exp_r.counts   = counts_full[COUNT_W-1:0];
            exp_r.feedback = fb_next[ANGLE_W-1:0];
            pulse_q.push_back(exp_r);
        endfunction

        function void flag(string field, longint want_v, longint got_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH result %0d %s: expected %0d, got %0d",
                         results, field, want_v, got_v);
        endfunction

        function void check_result(logic [CH_W-1:0] ch, logic [COUNT_W-1:0] counts,
                                   logic signed [ANGLE_W-1:0] fb);
            pulse_result_t want;
            results++;
            if (pulse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("MISMATCH result %0d: none expected (channel %0d, counts %0d)",
                             results, ch, counts);
                return;
            end
            want = pulse_q.pop_front();
            if (ch !== want.channel)
                flag("channel_out", want.channel, ch);
            if (counts !== want.counts)
                flag("high_counts", want.counts, counts);
            if (fb !== want.feedback)
                flag("feedback_angle", longint'(want.feedback), longint'(fb));
        endfunction

        function int pending();
            return pulse_q.size();
        endfunction
    endclass

endpackage

>>> verif/servo_angle_to_pulse_with_lag_tb.sv
// Self-checking testbench for servo_angle_to_pulse_with_lag: directed corner
// commands, then randomized traffic under several register settings and stalls.
// Depends on sapl_pkg, sapl_if, servo_pulse_tb_pkg and the block itself.
`timescale 1ns / 1ps

module servo_angle_to_pulse_with_lag_tb;
    import sapl_pkg::*;
    import servo_pulse_tb_pkg::*;

    localparam int N_CHANNELS      = 6;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    // Margin after draining so no command is still in flight before touching registers.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    // Longest stretch with no transfer on any channel before the run is declared hung.
    localparam int STALL_LIMIT     = 5000;
    localparam int ITEMS_PER_BLOCK = 100;
    localparam int RANDOM_BLOCKS   = 8;

    logic clk;
    logic rst_n = 1'b0;

    sapl_cmd_if cmd_bus ();
    sapl_res_if res_bus ();
    sapl_cfg_if cfg_bus ();

    servo_angle_to_pulse_with_lag #(
        .CHANNELS (N_CHANNELS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    pulse_scoreboard board = new(N_CHANNELS);

    // Idle percentages for the command sender and the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Raise to make the receiver drop ready for HOLD_OFF_CYCLES in a row.
    bit hold_off_req  = 1'b0;
    int reg_writes    = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Result side: check every transfer at the rising edge, pick the next ready
    // at the falling edge. A pending hold-off request is counted down here.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
                board.check_result(res_bus.channel_out, res_bus.high_counts,
                                   res_bus.feedback_angle);
            @(negedge clk);
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                res_bus.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, board.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Offer one command; called at a falling edge, returns at a falling edge.
    // Valid stays high on return so back-to-back commands need no gap.
    task automatic send_command(input logic [CH_W-1:0] ch,
                                input logic signed [ANGLE_W-1:0] angle);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid         = 1'b1;
        cmd_bus.channel_index = ch;
        cmd_bus.command_angle = angle;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        board.note_command(ch, angle);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        board.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Stop offering commands until every expected result is back, then let the
    // pipeline settle so a dropped command cannot overlap a register write.
    task automatic drain();
        cmd_bus.valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [CPU_W-1:0] cpu, input logic [GAIN_W-1:0] gain);
        drain();
        write_register(CFG_CLOCKS_PER_US, CFG_DATA_W'(cpu));
        write_register(CFG_FEEDBACK_GAIN, gain);
    endtask

    // Mix of fully random codes, in-range angles, angles around the clamp
    // points and a few fixed corners.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            v = $urandom_range(0, 65535);
        else if (sel < 70)
            v = int'($urandom_range(0, 46080)) - 23040;
        else if (sel < 85)
            v = ($urandom_range(0, 1) ? 23040 : -23040) + int'($urandom_range(0, 6)) - 3;
        else
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 32767;
                2: v = -32768;
                3: v = 1;
                default: v = -1;
            endcase
        return v[ANGLE_W-1:0];
    endfunction

    // Register values for a random block: extremes now and then, random otherwise.
    function automatic logic [CPU_W-1:0] pick_cpu();
        case ($urandom_range(0, 5))
            0: return 8'd1;
            1: return 8'd255;
            2: return 8'd0;
            default: return CPU_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return GAIN_MAX;
            2: return GAIN_W'($urandom_range(257, 511));
            default: return GAIN_W'($urandom_range(0, 256));
        endcase
    endfunction

    initial
    begin
        logic [CH_W-1:0] ch;
        int              accepted_in_block;

        cmd_bus.valid         = 1'b0;
        cmd_bus.channel_index = '0;
        cmd_bus.command_angle = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;

        // Hold reset, release it away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part under the reset register values: zero, both clamp
        // points, just past them, the field extremes, and dropped channels.
        send_command(3'd0, 16'sd0);
        send_command(3'd1, 16'sd23040);
        send_command(3'd2, -16'sd23040);
        send_command(3'd3, 16'sd32767);
        send_command(3'd4, 16'sh8000);
        send_command(3'd5, 16'sd23041);
        send_command(3'd0, -16'sd23041);
        send_command(3'd6, 16'sh1234);
        send_command(3'd7, -16'sd1);
        send_command(3'd1, 16'sd1);
        send_command(3'd2, -16'sd1);
        send_command(3'd3, 16'sh8000);
        send_command(3'd5, 16'sh5555);
        send_command(3'd4, 16'shAAAA);

        // Full gain and top clock rate: feedback jumps straight to the command,
        // including the widest swing of the error term.
        set_registers(8'd255, GAIN_MAX);
        send_command(3'd3, 16'sd32767);
        send_command(3'd3, 16'sh8000);
        send_command(3'd0, 16'sd23040);

        // Gain above full scale must saturate; zero clock rate gives zero counts.
        set_registers(8'd0, 9'd511);
        send_command(3'd1, 16'sd12345);
        send_command(3'd1, -16'sd20000);
        send_command(3'd7, 16'sd0);

        // Lowest clock rate, no feedback movement at all.
        set_registers(8'd1, 9'd0);
        send_command(3'd2, 16'sd32767);
        send_command(3'd5, -16'sd23040);

        // Random blocks: receiver-heavy idling first, then sender-heavy, then none.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            set_registers(pick_cpu(), pick_gain());
            if (blk < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 87;
            end
            else if (blk < 6)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Stall the result side for a long stretch while commands keep
            // coming, so the block backs up into its input.
            if (blk == 6)
                hold_off_req = 1'b1;

            // Every command counts, dropped channels included.
            accepted_in_block = 0;
            while (accepted_in_block < ITEMS_PER_BLOCK)
            begin
                ch = CH_W'($urandom_range(0, 7));
                send_command(ch, pick_angle());
                accepted_in_block++;
            end
        end

        drain();

        $display("Covered %0d commands (%0d to absent channels), %0d results,",
                 board.commands, board.dropped, board.results);
        $display("%0d register writes, idling on each side, a long result stall,",
                 reg_writes);
        $display("clock rate and gain extremes; %0d mismatches, %0d left over",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
